FILE: rtl/core/sfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared widths and constants of the sieve factorization engine.
// ----------------------------------------------------------------------------
package sfe_pkg;

   localparam int DataW      = 16;
   localparam int ExpW       = 5;
   localparam int MaxRes     = 6;
   localparam int ResCntW    = 3;
   localparam int ReqTdataW  = 16;
   localparam int RspTdataW  = 40;
   localparam int RspTuserW  = 1;
   localparam int DivCntW    = 5;

   // dividend, divisor and start of one division
   typedef struct packed {
      logic             start;
      logic [DataW-1:0] dividend;
      logic [DataW-1:0] divisor;
   } div_req_type;

   // result of the divider
   typedef struct packed {
      logic             done;
      logic [DataW-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/core/sfe_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_mul
// Shared multiplier with operand select and registered product.
// ----------------------------------------------------------------------------
module sfe_mul #(
   parameter int OPW = 16
) (
   input  logic             clock,
   input  logic             sel_walk,
   input  logic [OPW-1:0]   sieve_a,
   input  logic [OPW-1:0]   sieve_b,
   input  logic [OPW-1:0]   walk_a,
   input  logic [OPW-1:0]   walk_b,
   output logic [2*OPW-1:0] prod
);

   logic [OPW-1:0]   op_a;
   logic [OPW-1:0]   op_b;
   logic [2*OPW-1:0] prod_ff;
   logic [2*OPW-1:0] prod_in;

   always_comb begin
      op_a    = sel_walk ? walk_a : sieve_a;
      op_b    = sel_walk ? walk_b : sieve_b;
      prod_in = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/core/sfe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfe_div
   import sfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DataW:0]   rem_ff;
   logic [DataW-1:0] quo_ff;
   logic [DataW-1:0] dvs_ff;
   logic [DivCntW-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DataW:0]   rem_sh;
   logic             fits;

   always_comb begin
      rem_sh = {rem_ff[DataW-1:0], quo_ff[DataW-1]};
      fits   = (rem_sh >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         rem_ff  <= '0;
         quo_ff  <= req.dividend;
         dvs_ff  <= req.divisor;
         cnt_ff  <= DivCntW'(DataW);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_sh - {1'b0, dvs_ff};
         end else begin
            rem_ff <= rem_sh;
         end
         quo_ff <= {quo_ff[DataW-2:0], fits};
         cnt_ff <= cnt_ff - DivCntW'(1);
         if (cnt_ff == DivCntW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: rtl/core/sfe_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_mem
// Smallest prime factor and exponent tables, one write and one read port.
// ----------------------------------------------------------------------------
module sfe_mem
   import sfe_pkg::*;
#(
   parameter int MAX_N = 65536,
   parameter int AW    = 16
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [AW-1:0]   wr_lf,
   input  logic [ExpW-1:0] wr_lp,
   input  logic [AW-1:0]   rd_addr,
   output logic [AW-1:0]   rd_lf,
   output logic [ExpW-1:0] rd_lp
);

   logic [AW-1:0]   lf_mem [MAX_N];
   logic [ExpW-1:0] lp_mem [MAX_N];
   logic [AW-1:0]   rd_lf_ff;
   logic [ExpW-1:0] rd_lp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lf_mem[wr_addr] <= wr_lf;
         lp_mem[wr_addr] <= wr_lp;
      end
      rd_lf_ff <= lf_mem[rd_addr];
      rd_lp_ff <= lp_mem[rd_addr];
   end

   assign rd_lf = rd_lf_ff;
   assign rd_lp = rd_lp_ff;

endmodule

FILE: rtl/core/sfe_sieve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_sieve
// Clears the tables after reset, then runs the linear sieve over them.
// ----------------------------------------------------------------------------
module sfe_sieve
   import sfe_pkg::*;
#(
   parameter int MAX_N      = 65536,
   parameter int MAX_PRIMES = 4096,
   parameter int AW         = 16,
   parameter int OPW        = 16
) (
   input  logic             clock,
   input  logic             reset,
   output logic             done,
   output logic [AW-1:0]    rd_addr,
   input  logic [AW-1:0]    rd_lf,
   input  logic [ExpW-1:0]  rd_lp,
   output logic             wr_en,
   output logic [AW-1:0]    wr_addr,
   output logic [AW-1:0]    wr_lf,
   output logic [ExpW-1:0]  wr_lp,
   output logic [OPW-1:0]   mul_a,
   output logic [OPW-1:0]   mul_b,
   input  logic [2*OPW-1:0] prod
);

   localparam int PW    = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
   localparam int CW    = $clog2(MAX_PRIMES + 1);
   localparam int PRODW = 2 * OPW;

   localparam logic [AW-1:0]    LastClr = AW'(MAX_N - 1);
   localparam logic [AW-1:0]    LastI   = AW'(MAX_N / 2 - 1);
   localparam logic [PRODW-1:0] MaxN    = PRODW'(MAX_N);
   localparam logic [CW-1:0]    MaxP    = CW'(MAX_PRIMES);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_RD_I,
      S_CHK_I,
      S_RD_P,
      S_MUL_P,
      S_CHK_P,
      S_NEXT,
      S_DONE
   } state_type;

   state_type       state_ff;
   logic [AW-1:0]   clr_ff;
   logic [AW-1:0]   i_ff;
   logic [CW-1:0]   k_ff;
   logic [CW-1:0]   count_ff;
   logic [AW-1:0]   lp_ff;
   logic [ExpW-1:0] pw_ff;
   logic [AW-1:0]   p_ff;
   logic            done_ff;

   logic [AW-1:0]   plist [MAX_PRIMES];
   logic [AW-1:0]   plist_rd_ff;
   logic            plist_we;
   logic            prime_hit;
   logic            in_range;

   always_comb begin
      prime_hit = (rd_lf == '0);
      plist_we  = (state_ff == S_CHK_I) && prime_hit && (count_ff < MaxP);
      in_range  = (prod < MaxN);
   end

   always_ff @(posedge clock) begin
      if (plist_we) begin
         plist[count_ff[PW-1:0]] <= i_ff;
      end
      plist_rd_ff <= plist[k_ff[PW-1:0]];
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_lf   = '0;
      wr_lp   = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
         end
         S_CHK_I: begin
            wr_en   = prime_hit;
            wr_addr = i_ff;
            wr_lf   = i_ff;
            wr_lp   = ExpW'(1);
         end
         S_CHK_P: begin
            wr_en   = in_range;
            wr_addr = prod[AW-1:0];
            wr_lf   = p_ff;
            wr_lp   = (p_ff == lp_ff) ? pw_ff + ExpW'(1) : ExpW'(1);
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = i_ff;
   assign mul_a   = OPW'(plist_rd_ff);
   assign mul_b   = OPW'(i_ff);
   assign done    = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         i_ff     <= AW'(2);
         k_ff     <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == LastClr) begin
                  state_ff <= S_RD_I;
               end
            end
            S_RD_I: begin
               state_ff <= S_CHK_I;
            end
            S_CHK_I: begin
               if (prime_hit) begin
                  lp_ff <= i_ff;
                  pw_ff <= ExpW'(1);
                  if (count_ff < MaxP) begin
                     count_ff <= count_ff + CW'(1);
                  end
               end else begin
                  lp_ff <= rd_lf;
                  pw_ff <= rd_lp;
               end
               k_ff     <= '0;
               state_ff <= S_RD_P;
            end
            S_RD_P: begin
               if (k_ff < count_ff) begin
                  state_ff <= S_MUL_P;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_MUL_P: begin
               p_ff     <= plist_rd_ff;
               state_ff <= S_CHK_P;
            end
            S_CHK_P: begin
               if (!in_range || (p_ff == lp_ff)) begin
                  state_ff <= S_NEXT;
               end else begin
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= S_RD_P;
               end
            end
            S_NEXT: begin
               if (i_ff == LastI) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  i_ff     <= i_ff + AW'(1);
                  state_ff <= S_RD_I;
               end
            end
            S_DONE: begin
               state_ff <= S_DONE;
            end
            default: begin
               state_ff <= S_CLEAR;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/sieve_factorization_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sieve_factorization_engine_top
// Factors numbers by walking smallest prime factor tables built by a sieve.
//
// req channel: one number per transaction. rsp channel: one transaction per
// distinct prime in ascending order, tlast on the final one, which also holds
// the totient, square-free flag and prime count parity. Number 1 gives one
// transaction with prime 0; zero or a number not below MAX_N gives one
// transaction with tuser (range error) set.
// After reset req_tready stays low while the tables are cleared and then
// sieved, every number below MAX_N/2 in turn against the primes found so
// far. Zero, one and a range error go straight to the emit state and give
// their single transaction. Otherwise each distinct prime takes a table
// read, the power product on the shared multiplier, the division from
// divider start to quotient with the totient update in its shadow, and the
// emit. The divider sets the pace.
// Results leave through an output register; a stalled rsp side holds the
// walk only when the next result is ready, and a new number is taken while
// the last result still waits.
// ----------------------------------------------------------------------------
module sieve_factorization_engine_top
   import sfe_pkg::*;
#(
   parameter int MAX_N      = 65536,
   parameter int MAX_PRIMES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ReqTdataW-1:0] req_tdata,   // number
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RspTdataW-1:0] rsp_tdata,   // prime, exponent, totient,
                                             // square_free, odd_factor_count
   output logic                 rsp_tlast,   // last_factor
   output logic [RspTuserW-1:0] rsp_tuser    // range_error
);

   localparam int AW    = $clog2(MAX_N);
   localparam int OPW   = (AW > DataW) ? AW : DataW;
   localparam int PRODW = 2 * OPW;
   localparam int PPW   = 2 * DataW;

   localparam logic [PPW-1:0] MaxN = PPW'(MAX_N);

   typedef enum logic [3:0] {
      Q_IDLE,
      Q_RD,
      Q_LOOK,
      Q_PW,
      Q_PWW,
      Q_T1,
      Q_T2,
      Q_T3,
      Q_DIVW,
      Q_EMIT
   } state_type;

   typedef enum logic [1:0] {
      K_WALK,
      K_ONE,
      K_ERR
   } kind_type;

   // sieve side
   logic             sieve_done;
   logic [AW-1:0]    sieve_rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    wr_lf;
   logic [ExpW-1:0]  wr_lp;
   logic [OPW-1:0]   sieve_a;
   logic [OPW-1:0]   sieve_b;

   // shared units
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    rd_lf;
   logic [ExpW-1:0]  rd_lp;
   logic [OPW-1:0]   walk_a;
   logic [OPW-1:0]   walk_b;
   logic [PRODW-1:0] prod;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   // walk state
   state_type          state_ff;
   kind_type           kind_ff;
   logic [DataW-1:0]   n_ff;
   logic [DataW-1:0]   p_ff;
   logic [ExpW-1:0]    e_ff;
   logic [ExpW-1:0]    t_ff;
   logic [PPW-1:0]     pp_ff;
   logic [DataW-1:0]   ppprev_ff;
   logic [DataW-1:0]   tot_ff;
   logic               sqf_ff;
   logic               odd_ff;
   logic [ResCntW-1:0] cnt_ff;

   // output register
   logic               rsp_tvalid_ff;
   logic [DataW-1:0]   rsp_prime_ff;
   logic [ExpW-1:0]    rsp_exp_ff;
   logic [DataW-1:0]   rsp_tot_ff;
   logic               rsp_sqf_ff;
   logic               rsp_odd_ff;
   logic               rsp_last_ff;
   logic               rsp_err_ff;

   logic               accept;
   logic               out_free;
   logic               emit;
   logic               pp_big;
   logic               walk_last;
   logic [PPW-1:0]     req_num;

   sfe_sieve #(
      .MAX_N      (MAX_N),
      .MAX_PRIMES (MAX_PRIMES),
      .AW         (AW),
      .OPW        (OPW)
   ) u_sieve (
      .clock   (clock),
      .reset   (reset),
      .done    (sieve_done),
      .rd_addr (sieve_rd_addr),
      .rd_lf   (rd_lf),
      .rd_lp   (rd_lp),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_lf   (wr_lf),
      .wr_lp   (wr_lp),
      .mul_a   (sieve_a),
      .mul_b   (sieve_b),
      .prod    (prod)
   );

   sfe_mem #(
      .MAX_N (MAX_N),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_lf   (wr_lf),
      .wr_lp   (wr_lp),
      .rd_addr (rd_addr),
      .rd_lf   (rd_lf),
      .rd_lp   (rd_lp)
   );

   sfe_mul #(
      .OPW (OPW)
   ) u_mul (
      .clock    (clock),
      .sel_walk (sieve_done),
      .sieve_a  (sieve_a),
      .sieve_b  (sieve_b),
      .walk_a   (walk_a),
      .walk_b   (walk_b),
      .prod     (prod)
   );

   sfe_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      req_tready = sieve_done && (state_ff == Q_IDLE);
      accept     = req_tvalid && req_tready;
      out_free   = !rsp_tvalid_ff || rsp_tready;
      emit       = (state_ff == Q_EMIT) && out_free;
      rd_addr    = sieve_done ? AW'(n_ff) : sieve_rd_addr;
      pp_big     = (pp_ff[PPW-1:DataW] != '0);
      walk_last  = (n_ff <= DataW'(1)) || (cnt_ff == ResCntW'(MaxRes - 1));
      req_num    = PPW'(req_tdata[DataW-1:0]);

      walk_a = OPW'(pp_ff[DataW-1:0]);
      walk_b = OPW'(p_ff);
      unique case (state_ff)
         Q_T1: begin
            walk_a = OPW'(tot_ff);
            walk_b = OPW'(ppprev_ff);
         end
         Q_T2: begin
            walk_a = OPW'(prod[DataW-1:0]);
            walk_b = OPW'(p_ff - DataW'(1));
         end
         default: begin
         end
      endcase

      div_req.start    = (state_ff == Q_T1);
      div_req.dividend = n_ff;
      div_req.divisor  = pp_ff[DataW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= Q_IDLE;
         kind_ff       <= K_WALK;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            Q_IDLE: begin
               if (accept) begin
                  n_ff   <= req_tdata[DataW-1:0];
                  tot_ff <= DataW'(1);
                  sqf_ff <= 1'b1;
                  odd_ff <= 1'b0;
                  cnt_ff <= '0;
                  if ((req_num == '0) || (req_num >= MaxN)) begin
                     kind_ff  <= K_ERR;
                     state_ff <= Q_EMIT;
                  end else if (req_num == PPW'(1)) begin
                     kind_ff  <= K_ONE;
                     state_ff <= Q_EMIT;
                  end else begin
                     kind_ff  <= K_WALK;
                     state_ff <= Q_RD;
                  end
               end
            end
            Q_RD: begin
               state_ff <= Q_LOOK;
            end
            Q_LOOK: begin
               if ((rd_lf < AW'(2)) || (rd_lp == '0)) begin
                  p_ff <= n_ff;
                  e_ff <= ExpW'(1);
               end else begin
                  p_ff <= DataW'(rd_lf);
                  e_ff <= rd_lp;
               end
               pp_ff    <= PPW'(1);
               t_ff     <= '0;
               state_ff <= Q_PW;
            end
            Q_PW: begin
               if ((t_ff < e_ff) && (pp_ff <= PPW'(n_ff))) begin
                  ppprev_ff <= pp_ff[DataW-1:0];
                  t_ff      <= t_ff + ExpW'(1);
                  state_ff  <= Q_PWW;
               end else begin
                  state_ff <= Q_T1;
               end
            end
            Q_PWW: begin
               pp_ff    <= prod[PPW-1:0];
               state_ff <= Q_PW;
            end
            Q_T1: begin
               state_ff <= Q_T2;
            end
            Q_T2: begin
               state_ff <= Q_T3;
            end
            Q_T3: begin
               tot_ff <= prod[DataW-1:0];
               odd_ff <= odd_ff ^ e_ff[0];
               if (e_ff > ExpW'(1)) begin
                  sqf_ff <= 1'b0;
               end
               state_ff <= Q_DIVW;
            end
            Q_DIVW: begin
               if (div_rsp.done) begin
                  n_ff     <= pp_big ? '0 : div_rsp.quotient;
                  state_ff <= Q_EMIT;
               end
            end
            Q_EMIT: begin
               if (out_free) begin
                  unique case (kind_ff)
                     K_ERR: begin
                        rsp_prime_ff <= '0;
                        rsp_exp_ff   <= '0;
                        rsp_tot_ff   <= '0;
                        rsp_sqf_ff   <= 1'b0;
                        rsp_odd_ff   <= 1'b0;
                        rsp_last_ff  <= 1'b1;
                        rsp_err_ff   <= 1'b1;
                        state_ff     <= Q_IDLE;
                     end
                     K_ONE: begin
                        rsp_prime_ff <= '0;
                        rsp_exp_ff   <= '0;
                        rsp_tot_ff   <= DataW'(1);
                        rsp_sqf_ff   <= 1'b1;
                        rsp_odd_ff   <= 1'b0;
                        rsp_last_ff  <= 1'b1;
                        rsp_err_ff   <= 1'b0;
                        state_ff     <= Q_IDLE;
                     end
                     default: begin
                        rsp_prime_ff <= p_ff;
                        rsp_exp_ff   <= e_ff;
                        rsp_tot_ff   <= walk_last ? tot_ff : '0;
                        rsp_sqf_ff   <= walk_last && sqf_ff;
                        rsp_odd_ff   <= walk_last && odd_ff;
                        rsp_last_ff  <= walk_last;
                        rsp_err_ff   <= 1'b0;
                        if (walk_last) begin
                           state_ff <= Q_IDLE;
                        end else begin
                           cnt_ff   <= cnt_ff + ResCntW'(1);
                           state_ff <= Q_RD;
                        end
                     end
                  endcase
               end
            end
            default: begin
               state_ff <= Q_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_odd_ff, rsp_sqf_ff, rsp_tot_ff, rsp_exp_ff, rsp_prime_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

FILE: tb/tb_sieve_factorization_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sieve_factorization_engine_top
// Self-checking bench for the sieve factorization engine. It builds its own
// smallest prime factor tables with a linear sieve, predicts the factor
// transactions of every accepted number and compares each result
// transaction in order. Directed numbers cover zero, one, primes on both
// sides of the sieved half, high powers and six distinct primes; random
// numbers follow with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_sieve_factorization_engine_top;
   import sfe_pkg::*;

   localparam int unsigned TABLE_SIZE     = 65536;
   localparam int unsigned PRIME_CAPACITY = 4096;
   localparam int unsigned RANDOM_NUMBERS = 500;
   localparam int unsigned CALM_NUMBERS   = 100;
   localparam int unsigned WATCHDOG_LIMIT = 2000000;

   typedef struct packed {
      logic [DataW-1:0] prime;
      logic [ExpW-1:0]  exponent;
      logic             last_factor;
      logic [DataW-1:0] totient;
      logic             square_free;
      logic             odd_factor_count;
      logic             range_error;
   } factor_result_type;

   class factor_scoreboard;
      bit [DataW-1:0]     least_factor [TABLE_SIZE];
      bit [ExpW-1:0]      least_power [TABLE_SIZE];
      int unsigned        primes [PRIME_CAPACITY];
      int unsigned        prime_total;
      factor_result_type  expected_factors [$];
      int unsigned        mismatches;

      // linear sieve over the lower half only
      function new();
         int unsigned     i;
         int unsigned     k;
         int unsigned     lp;
         int unsigned     pw;
         int unsigned     p;
         longint unsigned idx;
         prime_total = 0;
         mismatches  = 0;
         for (i = 2; i < TABLE_SIZE / 2; i++) begin
            lp = 32'(least_factor[i]);
            pw = 32'(least_power[i]);
            if (lp == 0) begin
               lp = i;
               pw = 1;
               least_factor[i] = i[DataW-1:0];
               least_power[i]  = ExpW'(1);
               if (prime_total < PRIME_CAPACITY) begin
                  primes[prime_total] = i;
                  prime_total++;
               end
            end
            for (k = 0; k < prime_total; k++) begin
               p   = primes[k];
               idx = longint'(p) * i;
               if (idx >= TABLE_SIZE) break;
               least_factor[idx] = p[DataW-1:0];
               if (p == lp) begin
                  least_power[idx] = ExpW'(pw + 1);
                  break;
               end
               least_power[idx] = ExpW'(1);
            end
         end
      endfunction

      // walk the tables and queue the factor transactions of one number
      function void add_number(logic [DataW-1:0] number);
         int unsigned        n;
         int unsigned        p;
         int unsigned        e;
         int unsigned        t;
         int unsigned        total_exp;
         longint unsigned    pp;
         longint unsigned    tot;
         bit                 sqf;
         factor_result_type  r;
         factor_result_type  walk [$];
         r = '0;
         r.last_factor = 1'b1;
         if (number == 0 || number >= TABLE_SIZE) begin
            r.range_error = 1'b1;
            expected_factors.insert(expected_factors.size(), r);
            return;
         end
         if (number == 1) begin
            r.totient     = DataW'(1);
            r.square_free = 1'b1;
            expected_factors.insert(expected_factors.size(), r);
            return;
         end
         n         = 32'(number);
         tot       = 1;
         total_exp = 0;
         sqf       = 1'b1;
         while (n > 1 && walk.size() < MaxRes) begin
            p  = 32'(least_factor[n]);
            e  = 32'(least_power[n]);
            pp = 1;
            // upper half primes have no table entry
            if (p < 2 || e == 0) begin
               p = n;
               e = 1;
            end
            for (t = 0; t < e && pp <= n; t++) pp = pp * p;
            tot = tot * ((pp / p) * (p - 1));
            total_exp += e;
            if (e > 1) sqf = 1'b0;
            n = 32'(n / pp);
            r = '0;
            r.prime    = p[DataW-1:0];
            r.exponent = e[ExpW-1:0];
            walk.insert(walk.size(), r);
         end
         walk[walk.size()-1].last_factor      = 1'b1;
         walk[walk.size()-1].totient          = tot[DataW-1:0];
         walk[walk.size()-1].square_free      = sqf;
         walk[walk.size()-1].odd_factor_count = total_exp[0];
         foreach (walk[j]) expected_factors.insert(expected_factors.size(), walk[j]);
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_factor(logic [RspTdataW-1:0] data, logic last,
                                 logic [RspTuserW-1:0] user);
         factor_result_type want;
         if (expected_factors.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected transaction, expected none actual data %h last %b",
                     $time, data, last);
            return;
         end
         want = expected_factors.pop_front();
         compare("prime", want.prime, data[15:0]);
         compare("exponent", want.exponent, data[20:16]);
         compare("totient", want.totient, data[36:21]);
         compare("square_free", want.square_free, data[37]);
         compare("odd_factor_count", want.odd_factor_count, data[38]);
         compare("last_factor", want.last_factor, last);
         compare("range_error", want.range_error, user[0]);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ReqTdataW-1:0] req_tdata = '0;   // number
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic [RspTdataW-1:0] rsp_tdata;        // prime, exponent, totient,
                                           // square_free, odd_factor_count
   logic                 rsp_tlast;        // last_factor
   logic [RspTuserW-1:0] rsp_tuser;        // range_error

   factor_scoreboard factor_check;
   bit               idle_on = 1'b1;
   int unsigned      quiet_cycles = 0;
   int unsigned      small_primes [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
   int unsigned      directed_numbers [24] = '{0, 1, 2, 3, 4, 49, 97, 255, 16384,
      32768, 59049, 30030, 60060, 46189, 32767, 32749, 32771, 65498, 63001,
      65025, 65521, 65532, 65534, 65535};

   sieve_factorization_engine_top #(
      .MAX_N      (TABLE_SIZE),
      .MAX_PRIMES (PRIME_CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) factor_check.add_number(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            factor_check.check_factor(rsp_tdata, rsp_tlast, rsp_tuser);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side stalls
   initial begin
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   task automatic send_number(input logic [DataW-1:0] number);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= number;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_number();
      int unsigned n;
      int unsigned p;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         n = $urandom_range(0, 65535);
      end else if (pick < 40) begin
         n = $urandom_range(0, 300);
      end else if (pick < 70) begin
         // product of small primes, often many distinct ones
         n = 1;
         repeat ($urandom_range(1, 8)) begin
            p = small_primes[$urandom_range(0, 9)];
            if (n * p <= 65535) n = n * p;
         end
      end else if (pick < 85) begin
         p = small_primes[$urandom_range(0, 9)];
         n = p;
         while (n * p <= 65535 && $urandom_range(0, 4) != 0) n = n * p;
      end else if (pick < 95) begin
         // prime above the sieved half
         n = $urandom_range(32768, 65520);
         while (factor_check.least_factor[n] != 0) n++;
      end else begin
         n = $urandom_range(0, 1);
      end
      send_number(n[DataW-1:0]);
   endtask

   initial begin
      factor_check = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_numbers[i]) send_number(directed_numbers[i][DataW-1:0]);
      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         if (i == RANDOM_NUMBERS - CALM_NUMBERS) idle_on = 1'b0;
         send_random_number();
      end
      req_tvalid <= 1'b0;
      while (factor_check.expected_factors.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (factor_check.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
